// ===== rtl/core/hbtb_pkg.sv =====
`default_nettype none

package hbtb_pkg;

   // Field and pixel geometry.
   localparam int BYTE_W     = 8;
   localparam int CH_COUNT   = 4;
   localparam int TEXEL_W    = BYTE_W * CH_COUNT;
   localparam int REQ_W      = BYTE_W + 3 * TEXEL_W;
   localparam int RSP_W      = TEXEL_W;
   localparam int CNT_W      = 3;
   localparam int CSR_IDX_W  = 3;

   // Blend factor: 16 fraction bits, one integer bit so that 1.0 fits.
   localparam int FRAC_W     = 16;
   localparam int FACT_W     = FRAC_W + 1;
   localparam int PROD_W     = BYTE_W + FRAC_W + 2;

   // Divider layout: one quotient bit in setup, the rest spread over stages.
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = FRAC_W / DIV_STEPS;

   localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [BYTE_W-1:0] HEIGHT_MAX   = 8'hFF;
   localparam logic [CNT_W-1:0]  CNT_FULL     = 3'd4;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD_LOW     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD_HIGH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHAN_COUNT_FIRST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CHAN_COUNT_SECOND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CHAN_COUNT_THIRD  = 3'd4;

   // Register reset values.
   localparam logic [BYTE_W-1:0] THRESHOLD_LOW_RST  = 8'd85;
   localparam logic [BYTE_W-1:0] THRESHOLD_HIGH_RST = 8'd170;
   localparam logic [CNT_W-1:0]  CHAN_COUNT_RST     = 3'd4;

   typedef struct packed {
      logic [BYTE_W-1:0] thr_low;
      logic [BYTE_W-1:0] thr_high;
      logic [CNT_W-1:0]  cnt_first;
      logic [CNT_W-1:0]  cnt_second;
      logic [CNT_W-1:0]  cnt_third;
   } cfg_type;

   // Work item as it moves through the divider stages.
   typedef struct packed {
      logic [FACT_W-1:0]  quot;
      logic [BYTE_W-1:0]  rem;
      logic [BYTE_W-1:0]  span;
      logic               zero_span;
      logic [TEXEL_W-1:0] tex_lo;
      logic [TEXEL_W-1:0] tex_hi;
      logic               alpha_fixed;
   } div_type;

endpackage

`default_nettype wire

// ===== rtl/core/hbtb_setup.sv =====
`default_nettype none

module hbtb_setup import hbtb_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [REQ_W-1:0]   in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output div_type                 out_data
);

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;

   logic [BYTE_W-1:0]  height;
   logic [TEXEL_W-1:0] tex0;
   logic [TEXEL_W-1:0] tex1;
   logic [TEXEL_W-1:0] tex2;
   logic               below;
   logic               middle;
   logic [BYTE_W-1:0]  offset;
   logic [BYTE_W-1:0]  span;
   logic [CNT_W-1:0]   cnt_lo;
   logic [CNT_W-1:0]   cnt_hi;
   logic [TEXEL_W-1:0] raw_lo;
   logic [TEXEL_W-1:0] raw_hi;
   logic               top_bit;

   assign height = in_data[BYTE_W-1:0];
   assign tex0   = in_data[BYTE_W +: TEXEL_W];
   assign tex1   = in_data[BYTE_W + TEXEL_W +: TEXEL_W];
   assign tex2   = in_data[BYTE_W + 2 * TEXEL_W +: TEXEL_W];

   // Band select. The lower band reuses the blend path with both sides on
   // texture 0 and a zero factor, which gives texture 0 unchanged.
   always_comb begin
      below  = height < cfg.thr_low;
      middle = !below && (height < cfg.thr_high);
      if (below) begin
         offset = '0;
         span   = 8'd1;
         raw_lo = tex0;
         raw_hi = tex0;
         cnt_lo = cfg.cnt_first;
         cnt_hi = cfg.cnt_first;
      end else if (middle) begin
         offset = height - cfg.thr_low;
         span   = cfg.thr_high - cfg.thr_low;
         raw_lo = tex0;
         raw_hi = tex1;
         cnt_lo = cfg.cnt_first;
         cnt_hi = cfg.cnt_second;
      end else begin
         offset = height - cfg.thr_high;
         span   = HEIGHT_MAX - cfg.thr_high;
         raw_lo = tex1;
         raw_hi = tex2;
         cnt_lo = cfg.cnt_second;
         cnt_hi = cfg.cnt_third;
      end
   end

   // Channel masking, first quotient bit, and the alpha override.
   always_comb begin
      top_bit = offset >= span;
      data_in.quot        = {{(FACT_W-1){1'b0}}, top_bit};
      data_in.rem         = top_bit ? offset - span : offset;
      data_in.span        = span;
      data_in.zero_span   = below || (span == '0);
      data_in.alpha_fixed = (cnt_lo < CNT_FULL) && (cnt_hi < CNT_FULL);
      for (int ch = 0; ch < CH_COUNT; ch++) begin
         data_in.tex_lo[ch*BYTE_W +: BYTE_W] =
            (cnt_lo > CNT_W'(ch)) ? raw_lo[ch*BYTE_W +: BYTE_W] : '0;
         data_in.tex_hi[ch*BYTE_W +: BYTE_W] =
            (cnt_hi > CNT_W'(ch)) ? raw_hi[ch*BYTE_W +: BYTE_W] : '0;
      end
   end

   // Stage register; it refills whenever it is empty or drains.
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hbtb_div_stage.sv =====
`default_nettype none

module hbtb_div_stage import hbtb_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire div_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output div_type      out_data
);

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;

   logic [FACT_W-1:0] quot;
   logic [BYTE_W-1:0] rem;
   logic [BYTE_W:0]   shifted;
   logic              fits;

   // Restoring division steps. The remainder stays below the divisor, so
   // it fits in a byte and the shifted value in nine bits.
   always_comb begin
      quot    = in_data.quot;
      rem     = in_data.rem;
      shifted = '0;
      fits    = 1'b0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         shifted = {rem, 1'b0};
         fits    = shifted >= {1'b0, in_data.span};
         quot    = {quot[FACT_W-2:0], fits};
         rem     = fits ? BYTE_W'(shifted - {1'b0, in_data.span}) : shifted[BYTE_W-1:0];
      end
      data_in      = in_data;
      data_in.quot = quot;
      data_in.rem  = rem;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hbtb_mix.sv =====
`default_nettype none

module hbtb_mix import hbtb_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire div_type          in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [RSP_W-1:0]      out_data
);

   // Multiply stage registers.
   logic                             mul_valid_ff;
   logic [CH_COUNT-1:0][BYTE_W-1:0]  base_ff;
   logic [CH_COUNT-1:0][PROD_W-1:0]  prod_ff;
   logic                             alpha_fixed_ff;
   logic [CH_COUNT-1:0][PROD_W-1:0]  prod_in;
   logic                             mul_ready;

   // Sum stage registers.
   logic                             sum_valid_ff;
   logic [RSP_W-1:0]                 pixel_ff;
   logic [RSP_W-1:0]                 pixel_in;

   logic [FACT_W-1:0]                factor;
   logic signed [BYTE_W:0]           diff;
   logic signed [BYTE_W+FACT_W+1:0]  prod_full;
   logic signed [PROD_W-1:0]         sum;

   // One lane per channel: (b - a) * f, so that the result is a + that / 2^16.
   always_comb begin
      factor    = in_data.zero_span ? '0 : in_data.quot;
      diff      = '0;
      prod_full = '0;
      for (int ch = 0; ch < CH_COUNT; ch++) begin
         diff = $signed({1'b0, in_data.tex_hi[ch*BYTE_W +: BYTE_W]})
              - $signed({1'b0, in_data.tex_lo[ch*BYTE_W +: BYTE_W]});
         prod_full   = diff * $signed({1'b0, factor});
         prod_in[ch] = prod_full[PROD_W-1:0];
      end
   end

   assign mul_ready = !sum_valid_ff || out_ready;
   assign in_ready  = !mul_valid_ff || mul_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (in_ready) begin
         mul_valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         prod_ff        <= prod_in;
         alpha_fixed_ff <= in_data.alpha_fixed;
         for (int ch = 0; ch < CH_COUNT; ch++) begin
            base_ff[ch] <= in_data.tex_lo[ch*BYTE_W +: BYTE_W];
         end
      end
   end

   // Add the scaled difference; the sum is never negative, so taking its
   // upper bits truncates toward zero.
   always_comb begin
      sum = '0;
      for (int ch = 0; ch < CH_COUNT; ch++) begin
         sum = $signed({2'b00, base_ff[ch], {FRAC_W{1'b0}}}) + $signed(prod_ff[ch]);
         pixel_in[ch*BYTE_W +: BYTE_W] = sum[FRAC_W +: BYTE_W];
      end
      if (alpha_fixed_ff) begin
         pixel_in[(CH_COUNT-1)*BYTE_W +: BYTE_W] = ALPHA_OPAQUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         sum_valid_ff <= mul_valid_ff;
      end
      if (mul_valid_ff && mul_ready) begin
         pixel_ff <= pixel_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign out_data  = pixel_ff;

endmodule

`default_nettype wire

// ===== rtl/core/height_band_texture_blend.sv =====
// Throughput: one pixel per cycle unless rsp_tready stalls the pipeline. A pixel
// passes the setup register, then the factor divider, which gives four quotient
// bits in each of four pipeline stages, then the two-stage blend (multiply, sum).
// Reset (synchronous, active high) empties every stage and restores the
// thresholds to 85 and 170 and all channel counts to 4.
`default_nettype none

module height_band_texture_blend import hbtb_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Input pixel, from bit 0: height_sample[7:0], first_texel[31:0],
   // second_texel[31:0], third_texel[31:0].
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [REQ_W-1:0]     req_tdata,
   // Result pixel, from bit 0: out_red, out_green, out_blue, out_alpha.
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RSP_W-1:0]          rsp_tdata,
   // Register writes.
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [BYTE_W-1:0]    csr_data
);

   cfg_type cfg_ff;

   logic    div_valid [DIV_STAGES+1];
   logic    div_ready [DIV_STAGES+1];
   div_type div_data  [DIV_STAGES+1];

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thr_low    <= THRESHOLD_LOW_RST;
         cfg_ff.thr_high   <= THRESHOLD_HIGH_RST;
         cfg_ff.cnt_first  <= CHAN_COUNT_RST;
         cfg_ff.cnt_second <= CHAN_COUNT_RST;
         cfg_ff.cnt_third  <= CHAN_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_THRESHOLD_LOW:     cfg_ff.thr_low    <= csr_data;
            REG_THRESHOLD_HIGH:    cfg_ff.thr_high   <= csr_data;
            REG_CHAN_COUNT_FIRST:  cfg_ff.cnt_first  <= csr_data[CNT_W-1:0];
            REG_CHAN_COUNT_SECOND: cfg_ff.cnt_second <= csr_data[CNT_W-1:0];
            REG_CHAN_COUNT_THIRD:  cfg_ff.cnt_third  <= csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Band select, masking and first quotient bit.
   hbtb_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   // Divider pipeline for the blend factor.
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      hbtb_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[s]),
         .in_ready  (div_ready[s]),
         .in_data   (div_data[s]),
         .out_valid (div_valid[s+1]),
         .out_ready (div_ready[s+1]),
         .out_data  (div_data[s+1])
      );
   end

   // Channel blend.
   hbtb_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid[DIV_STAGES]),
      .in_ready  (div_ready[DIV_STAGES]),
      .in_data   (div_data[DIV_STAGES]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   // A finished factor never exceeds 1.0 when the span is nonzero.
   a_factor_range: assert property (@(posedge clock) disable iff (reset)
      div_valid[DIV_STAGES] && !div_data[DIV_STAGES].zero_span |->
         div_data[DIV_STAGES].quot <= {1'b1, {FRAC_W{1'b0}}})
      else $error("blend factor above one");

   // With the output stage empty every stage upstream can take a beat.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty output stage");

   // Reset empties the pipeline.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire
